// ===== rtl/hfve_pkg.sv =====
`timescale 1ns / 1ps
// hfve_pkg: types, character codes and helpers shared by the header field
// value extractor. No dependencies.
package hfve_pkg;

    localparam int CMDQ_DEPTH = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] CFG_NAME_LEN  = 2'd0;
    localparam logic [1:0] CFG_NAME_LOW  = 2'd1;
    localparam logic [1:0] CFG_NAME_HIGH = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_NO_MATCH = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       pending_overflow;
        logic       run_last;
    } t_out_item;

    typedef enum logic [5:0] {
        PH_LINE_START = 6'b000001,
        PH_COMPARE    = 6'b000010,
        PH_SKIP_LINE  = 6'b000100,
        PH_LEAD       = 6'b001000,
        PH_VALUE      = 6'b010000,
        PH_DONE       = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_PUSH_SP = 3'd1,
        ACT_PUSH_NL = 3'd2,
        ACT_PRINT   = 3'd3,
        ACT_FINISH  = 3'd4
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [7:0] data;
        t_kind      fin_kind;
        logic       has_tail;
        t_kind      tail_kind;
        logic       last;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_HEAD = 2'b01,
        BK_TAIL = 2'b10
    } t_bstate;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

// ===== rtl/hfve_front.sv =====
`timescale 1ns / 1ps
// hfve_front: configuration registers, name match and line parser; turns each
// header byte into at most one command for the back end. Uses hfve_pkg.
module hfve_front #(
    parameter int NAME_MAX = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_accept,
    input  hfve_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output hfve_pkg::t_cmd     o_cmd
);

    logic [4:0]       r_name_len;
    logic [127:0]     r_name;
    hfve_pkg::t_phase r_phase, n_phase;
    logic [4:0]       r_pos, n_pos;
    logic             r_nl, n_nl;

    logic [7:0]       b;
    logic [4:0]       len;
    logic [4:0]       pos_eff;
    logic [7:0]       nc;
    logic             cmp_hit;
    logic             cmp_colon;
    logic             is_ws;
    hfve_pkg::t_act   act;
    hfve_pkg::t_kind  fin_kind;
    hfve_pkg::t_phase cmp_phase;
    logic [4:0]       cmp_pos;
    logic             cmp_fin;

    assign b       = i_item.in_byte;
    assign len     = (r_name_len > 5'(NAME_MAX)) ? 5'(NAME_MAX) : r_name_len;
    assign pos_eff = (r_phase == hfve_pkg::PH_LINE_START) ? 5'd0 : r_pos;
    assign nc      = r_name[{pos_eff[3:0], 3'b000} +: 8];
    assign cmp_hit = (pos_eff < len) && (b != hfve_pkg::CH_NUL) && (b != hfve_pkg::CH_LF)
                     && (hfve_pkg::to_lower(b) == hfve_pkg::to_lower(nc));
    assign cmp_colon = (pos_eff >= len) && (b == hfve_pkg::CH_COLON);
    assign is_ws   = (b == hfve_pkg::CH_SP) || (b == hfve_pkg::CH_TAB)
                     || (b == hfve_pkg::CH_CR) || (b == hfve_pkg::CH_LF);

    always_comb begin
        cmp_pos = pos_eff;
        cmp_fin = 1'b0;
        priority if (cmp_hit) begin
            cmp_pos   = pos_eff + 5'd1;
            cmp_phase = hfve_pkg::PH_COMPARE;
        end else if (cmp_colon) begin
            cmp_phase = hfve_pkg::PH_LEAD;
        end else if (b == hfve_pkg::CH_NUL) begin
            cmp_phase = hfve_pkg::PH_DONE;
            cmp_fin   = 1'b1;
        end else if (b == hfve_pkg::CH_LF) begin
            cmp_phase = hfve_pkg::PH_LINE_START;
        end else begin
            cmp_phase = hfve_pkg::PH_SKIP_LINE;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_nl     = r_nl;
        act      = hfve_pkg::ACT_NONE;
        fin_kind = hfve_pkg::KIND_COMPLETE;
        unique case (r_phase)
            hfve_pkg::PH_LINE_START: begin
                if (b == hfve_pkg::CH_NUL) begin
                    n_phase  = hfve_pkg::PH_DONE;
                    act      = hfve_pkg::ACT_FINISH;
                    fin_kind = hfve_pkg::KIND_NO_MATCH;
                end else if (b == hfve_pkg::CH_TAB) begin
                    n_phase = hfve_pkg::PH_SKIP_LINE;
                end else begin
                    n_phase = cmp_phase;
                    n_pos   = cmp_pos;
                    if (cmp_fin) begin
                        act      = hfve_pkg::ACT_FINISH;
                        fin_kind = hfve_pkg::KIND_NO_MATCH;
                    end
                end
            end
            hfve_pkg::PH_COMPARE: begin
                n_phase = cmp_phase;
                n_pos   = cmp_pos;
                if (cmp_fin) begin
                    act      = hfve_pkg::ACT_FINISH;
                    fin_kind = hfve_pkg::KIND_NO_MATCH;
                end
            end
            hfve_pkg::PH_SKIP_LINE: begin
                if (b == hfve_pkg::CH_NUL) begin
                    n_phase  = hfve_pkg::PH_DONE;
                    act      = hfve_pkg::ACT_FINISH;
                    fin_kind = hfve_pkg::KIND_NO_MATCH;
                end else if (b == hfve_pkg::CH_LF) begin
                    n_phase = hfve_pkg::PH_LINE_START;
                end
            end
            hfve_pkg::PH_LEAD: begin
                if (r_nl) begin
                    n_nl = 1'b0;
                    if (!is_ws) begin
                        n_phase = hfve_pkg::PH_DONE;
                        act     = hfve_pkg::ACT_FINISH;
                    end
                end else if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB
                             || b == hfve_pkg::CH_CR) begin
                    n_nl = 1'b0;
                end else if (b == hfve_pkg::CH_LF) begin
                    n_nl = 1'b1;
                end else if (b == hfve_pkg::CH_NUL) begin
                    n_phase = hfve_pkg::PH_DONE;
                    act     = hfve_pkg::ACT_FINISH;
                end else begin
                    n_phase = hfve_pkg::PH_VALUE;
                    act     = hfve_pkg::ACT_PRINT;
                end
            end
            hfve_pkg::PH_VALUE: begin
                if (r_nl) begin
                    n_nl = 1'b0;
                    if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB) begin
                        act = hfve_pkg::ACT_PUSH_NL;
                    end else begin
                        n_phase = hfve_pkg::PH_DONE;
                        act     = hfve_pkg::ACT_FINISH;
                    end
                end else if (b == hfve_pkg::CH_NUL) begin
                    n_phase = hfve_pkg::PH_DONE;
                    act     = hfve_pkg::ACT_FINISH;
                end else if (b == hfve_pkg::CH_CR) begin
                    n_nl = 1'b0;
                end else if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB) begin
                    act = hfve_pkg::ACT_PUSH_SP;
                end else if (b == hfve_pkg::CH_LF) begin
                    n_nl = 1'b1;
                end else begin
                    act = hfve_pkg::ACT_PRINT;
                end
            end
            hfve_pkg::PH_DONE: begin
                n_phase = hfve_pkg::PH_DONE;
            end
            default: begin
                n_phase = hfve_pkg::PH_LINE_START;
            end
        endcase

        o_cmd.act       = act;
        o_cmd.data      = (b == hfve_pkg::CH_TAB) ? hfve_pkg::CH_SP : b;
        o_cmd.fin_kind  = fin_kind;
        o_cmd.last      = i_item.end_of_buffer;
        o_cmd.has_tail  = i_item.end_of_buffer && (n_phase != hfve_pkg::PH_DONE);
        o_cmd.tail_kind = (n_phase == hfve_pkg::PH_LEAD || n_phase == hfve_pkg::PH_VALUE)
                          ? hfve_pkg::KIND_COMPLETE : hfve_pkg::KIND_NO_MATCH;
        o_cmd_valid     = i_accept && (act != hfve_pkg::ACT_NONE || i_item.end_of_buffer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len <= 5'd1;
            r_name     <= '0;
            r_phase    <= hfve_pkg::PH_LINE_START;
            r_pos      <= '0;
            r_nl       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    hfve_pkg::CFG_NAME_LEN:  r_name_len     <= i_cfg_data[4:0];
                    hfve_pkg::CFG_NAME_LOW:  r_name[63:0]   <= i_cfg_data;
                    hfve_pkg::CFG_NAME_HIGH: r_name[127:64] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (i_item.end_of_buffer) begin
                    r_phase <= hfve_pkg::PH_LINE_START;
                    r_pos   <= '0;
                    r_nl    <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_nl    <= n_nl;
                end
            end
        end
    end

endmodule

// ===== rtl/hfve_cmdq.sv =====
`timescale 1ns / 1ps
// hfve_cmdq: short command queue between the parser and the result generator.
// Uses hfve_pkg.
module hfve_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  hfve_pkg::t_cmd i_wr_cmd,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output hfve_pkg::t_cmd o_rd_cmd
);

    localparam int PW = $clog2(hfve_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(hfve_pkg::CMDQ_DEPTH + 1);

    hfve_pkg::t_cmd r_mem [hfve_pkg::CMDQ_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_wr;
    logic           do_rd;

    assign o_full   = (r_cnt == CW'(hfve_pkg::CMDQ_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_rd_cmd = r_mem[r_rp];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PW'(hfve_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PW'(hfve_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_wr) - CW'(do_rd);
        end
    end

endmodule

// ===== rtl/hfve_back.sv =====
`timescale 1ns / 1ps
// hfve_back: pending whitespace store, result sequencing and output register.
// Uses hfve_pkg.
module hfve_back #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  hfve_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output hfve_pkg::t_out_item o_result
);

    localparam int CNTW = $clog2(PENDING_DEPTH + 1);
    localparam int IDXW = $clog2(PENDING_DEPTH);

    logic                r_pend [PENDING_DEPTH];
    logic [CNTW-1:0]     r_count, n_count;
    logic [CNTW-1:0]     r_idx, n_idx;
    logic                r_ovf, n_ovf;
    hfve_pkg::t_bstate   r_state, n_state;
    logic                r_valid;
    hfve_pkg::t_out_item r_out;

    logic                out_rdy;
    logic                emit;
    hfve_pkg::t_out_item res;
    logic                ok0, ok1;
    logic [CNTW-1:0]     cnt1;
    logic                w0_en, w1_en, w0_val;
    logic [IDXW-1:0]     w0_addr, w1_addr;

    assign out_rdy  = !r_valid || i_pop;
    assign o_empty  = !r_valid;
    assign o_result = r_out;
    assign ok0      = (r_count < CNTW'(PENDING_DEPTH));
    assign cnt1     = r_count + {{(CNTW-1){1'b0}}, ok0};
    assign ok1      = (cnt1 < CNTW'(PENDING_DEPTH));

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_ovf     = r_ovf;
        n_state   = r_state;
        emit      = 1'b0;
        o_cmd_pop = 1'b0;
        w0_en     = 1'b0;
        w1_en     = 1'b0;
        w0_val    = 1'b0;
        w0_addr   = r_count[IDXW-1:0];
        w1_addr   = cnt1[IDXW-1:0];
        res.kind             = hfve_pkg::KIND_BYTE;
        res.out_byte         = 8'h00;
        res.pending_overflow = r_ovf;
        res.run_last         = 1'b1;
        if (i_cmd_valid && out_rdy) begin
            unique case (r_state)
                hfve_pkg::BK_HEAD: begin
                    unique case (i_cmd.act)
                        hfve_pkg::ACT_PUSH_SP, hfve_pkg::ACT_PUSH_NL: begin
                            w0_en = ok0;
                            if (i_cmd.act == hfve_pkg::ACT_PUSH_NL) begin
                                w0_val  = 1'b1;
                                w1_en   = ok1;
                                n_count = cnt1 + {{(CNTW-1){1'b0}}, ok1};
                                n_ovf   = r_ovf || !ok0 || !ok1;
                            end else begin
                                n_count = cnt1;
                                n_ovf   = r_ovf || !ok0;
                            end
                            emit                 = i_cmd.has_tail;
                            res.kind             = i_cmd.tail_kind;
                            res.pending_overflow = n_ovf;
                            o_cmd_pop            = 1'b1;
                        end
                        hfve_pkg::ACT_PRINT: begin
                            emit = 1'b1;
                            if (r_idx < r_count) begin
                                res.out_byte = r_pend[r_idx[IDXW-1:0]] ? hfve_pkg::CH_LF
                                                                        : hfve_pkg::CH_SP;
                                res.run_last = 1'b0;
                                n_idx        = r_idx + 1'b1;
                            end else begin
                                res.out_byte = i_cmd.data;
                                res.run_last = !i_cmd.has_tail;
                                n_count      = '0;
                                n_idx        = '0;
                                if (i_cmd.has_tail) begin
                                    n_state = hfve_pkg::BK_TAIL;
                                end else begin
                                    o_cmd_pop = 1'b1;
                                end
                            end
                        end
                        hfve_pkg::ACT_FINISH: begin
                            emit      = 1'b1;
                            res.kind  = i_cmd.fin_kind;
                            o_cmd_pop = 1'b1;
                        end
                        default: begin
                            emit      = i_cmd.has_tail;
                            res.kind  = i_cmd.tail_kind;
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
                hfve_pkg::BK_TAIL: begin
                    emit      = 1'b1;
                    res.kind  = i_cmd.tail_kind;
                    o_cmd_pop = 1'b1;
                    n_state   = hfve_pkg::BK_HEAD;
                end
                default: begin
                    n_state = hfve_pkg::BK_HEAD;
                end
            endcase
            if (o_cmd_pop && i_cmd.last) begin
                n_count = '0;
                n_idx   = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < PENDING_DEPTH; j++) begin
            if (w0_en && w0_addr == IDXW'(j)) begin
                r_pend[j] <= w0_val;
            end
            if (w1_en && w1_addr == IDXW'(j)) begin
                r_pend[j] <= 1'b0;
            end
        end
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_state <= hfve_pkg::BK_HEAD;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            r_state <= n_state;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/header_field_value_extract_top.sv =====
`timescale 1ns / 1ps
// Header field value extractor: takes one header byte per cycle while full is
// low and hands out the value of the first line whose name matches the
// configured one. The front end parses a byte per cycle and posts at most one
// command per byte into a four-entry command queue; the back end turns each
// command into results at one per cycle through a single output register, and
// a command retires only while that register is free or being popped. The
// first result of a byte is registered in the command queue and then in the
// output register before it can be popped. A printable value byte preceded
// by n held whitespace bytes yields n+1 results, plus one more when the same
// byte ends the buffer, so full rises while that queue is filled behind such
// flushes or behind results that are not popped. No clearing pass after reset.
// Uses hfve_pkg, hfve_front, hfve_cmdq and hfve_back.
module header_field_value_extract_top #(
    parameter int NAME_MAX      = 16,
    parameter int PENDING_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                push,
    output logic                full,
    input  hfve_pkg::t_in_item  i_in,
    output logic                empty,
    input  logic                pop,
    output hfve_pkg::t_out_item o_out
);

    logic           q_full;
    logic           accept;
    logic           cmd_wr;
    hfve_pkg::t_cmd cmd_in;
    logic           cmd_valid;
    hfve_pkg::t_cmd cmd_head;
    logic           cmd_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    hfve_front #(
        .NAME_MAX(NAME_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in),
        .o_cmd_valid(cmd_wr),
        .o_cmd      (cmd_in)
    );

    hfve_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wr_cmd(cmd_in),
        .o_full  (q_full),
        .i_rd    (cmd_pop),
        .o_valid (cmd_valid),
        .o_rd_cmd(cmd_head)
    );

    hfve_back #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd_head),
        .o_cmd_pop  (cmd_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_out)
    );

endmodule

// ===== rtl/hfve_checker.sv =====
`timescale 1ns / 1ps
// hfve_checker: port-level checks of the result queue of the extractor, and
// the bind that attaches them to the top level. Uses hfve_pkg.
module hfve_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input hfve_pkg::t_out_item o_out
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.kind != hfve_pkg::KIND_BYTE) |-> (o_out.out_byte == 8'h00))
        else $error("end marker carries a nonzero byte");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.kind != hfve_pkg::KIND_BYTE) |-> o_out.run_last)
        else $error("end marker not last of its run");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.kind == hfve_pkg::KIND_BYTE || o_out.kind == hfve_pkg::KIND_COMPLETE
                    || o_out.kind == hfve_pkg::KIND_NO_MATCH))
        else $error("illegal result kind");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed before transfer");

endmodule

bind header_field_value_extract_top hfve_checker u_hfve_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .empty  (empty),
    .pop    (pop),
    .o_out  (o_out)
);

// ===== tb/header_field_value_extract_checker.sv =====
`timescale 1ns / 1ps
// Checker for the header field value extractor: predicts every result of each accepted
// header byte and compares popped results field by field. Depends on hfve_pkg only.
module header_field_value_extract_checker #(
    parameter int NAME_MAX      = 16,
    parameter int PENDING_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_push,
    input  logic                i_full,
    input  hfve_pkg::t_in_item  i_in,
    input  logic                i_empty,
    input  logic                i_pop,
    input  hfve_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_waiting,
    output int                  o_checked,
    output int                  o_overflow_hits
);

    logic [4:0]  name_len_reg = 5'd1;
    logic [63:0] name_lo_reg  = '0;
    logic [63:0] name_hi_reg  = '0;

    hfve_pkg::t_phase ph = hfve_pkg::PH_LINE_START;
    int          name_pos = 0;
    logic        nl_held = 1'b0;
    int          ws_count = 0;
    logic        ws_is_nl [PENDING_DEPTH];
    logic        ws_overflow = 1'b0;

    hfve_pkg::t_out_item value_q [$];
    int          step_n;
    int          fails = 0;
    int          waiting = 0;
    int          checked = 0;
    int          overflow_hits = 0;

    assign o_fail_count    = fails;
    assign o_waiting       = waiting;
    assign o_checked       = checked;
    assign o_overflow_hits = overflow_hits;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] wanted_char(input int i);
        if (i < 8) return name_lo_reg[8*i +: 8];
        return name_hi_reg[8*(i-8) +: 8];
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB || b == hfve_pkg::CH_CR
               || b == hfve_pkg::CH_LF;
    endfunction

    task automatic post(input hfve_pkg::t_kind k, input logic [7:0] b);
        hfve_pkg::t_out_item r;
        r.kind             = k;
        r.out_byte         = (k == hfve_pkg::KIND_BYTE) ? b : 8'h00;
        r.pending_overflow = ws_overflow;
        r.run_last         = 1'b0;
        value_q.push_back(r);
        step_n++;
    endtask

    task automatic finish_run(input hfve_pkg::t_kind k);
        post(k, 8'h00);
        ph = hfve_pkg::PH_DONE;
    endtask

    task automatic hold_ws(input logic is_nl);
        if (ws_count < PENDING_DEPTH) begin
            ws_is_nl[ws_count] = is_nl;
            ws_count++;
        end else begin
            ws_overflow = 1'b1;
        end
    endtask

    task automatic flush_and_print(input logic [7:0] b);
        for (int i = 0; i < ws_count; i++)
            post(hfve_pkg::KIND_BYTE, ws_is_nl[i] ? hfve_pkg::CH_LF : hfve_pkg::CH_SP);
        ws_count = 0;
        post(hfve_pkg::KIND_BYTE, b);
        ph = hfve_pkg::PH_VALUE;
    endtask

    task automatic match_name_byte(input logic [7:0] b);
        int   eff;
        logic took;
        eff  = (int'(name_len_reg) > NAME_MAX) ? NAME_MAX : int'(name_len_reg);
        took = 1'b0;
        if (name_pos < eff) begin
            if (b != hfve_pkg::CH_NUL && b != hfve_pkg::CH_LF
                && fold_case(b) == fold_case(wanted_char(name_pos))) begin
                name_pos++;
                ph   = hfve_pkg::PH_COMPARE;
                took = 1'b1;
            end
        end else if (b == hfve_pkg::CH_COLON) begin
            ph   = hfve_pkg::PH_LEAD;
            took = 1'b1;
        end
        if (!took) begin
            if (b == hfve_pkg::CH_NUL)
                finish_run(hfve_pkg::KIND_NO_MATCH);
            else if (b == hfve_pkg::CH_LF)
                ph = hfve_pkg::PH_LINE_START;
            else
                ph = hfve_pkg::PH_SKIP_LINE;
        end
    endtask

    task automatic clear_parse();
        ph          = hfve_pkg::PH_LINE_START;
        name_pos    = 0;
        nl_held     = 1'b0;
        ws_count    = 0;
        ws_overflow = 1'b0;
    endtask

    task automatic predict_item(input hfve_pkg::t_in_item it);
        logic [7:0]          b;
        hfve_pkg::t_out_item last_r;
        b      = it.in_byte;
        step_n = 0;
        case (ph)
            hfve_pkg::PH_LINE_START: begin
                if (b == hfve_pkg::CH_NUL)
                    finish_run(hfve_pkg::KIND_NO_MATCH);
                else if (b == hfve_pkg::CH_TAB)
                    ph = hfve_pkg::PH_SKIP_LINE;
                else begin
                    name_pos = 0;
                    match_name_byte(b);
                end
            end
            hfve_pkg::PH_COMPARE: match_name_byte(b);
            hfve_pkg::PH_SKIP_LINE: begin
                if (b == hfve_pkg::CH_NUL)
                    finish_run(hfve_pkg::KIND_NO_MATCH);
                else if (b == hfve_pkg::CH_LF)
                    ph = hfve_pkg::PH_LINE_START;
            end
            hfve_pkg::PH_LEAD: begin
                if (nl_held) begin
                    nl_held = 1'b0;
                    if (!is_blank(b))
                        finish_run(hfve_pkg::KIND_COMPLETE);
                end else if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB
                             || b == hfve_pkg::CH_CR) begin
                end else if (b == hfve_pkg::CH_LF)
                    nl_held = 1'b1;
                else if (b == hfve_pkg::CH_NUL)
                    finish_run(hfve_pkg::KIND_COMPLETE);
                else
                    flush_and_print(b);
            end
            hfve_pkg::PH_VALUE: begin
                if (nl_held) begin
                    nl_held = 1'b0;
                    if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB) begin
                        hold_ws(1'b1);
                        hold_ws(1'b0);
                    end else begin
                        finish_run(hfve_pkg::KIND_COMPLETE);
                    end
                end else if (b == hfve_pkg::CH_NUL)
                    finish_run(hfve_pkg::KIND_COMPLETE);
                else if (b == hfve_pkg::CH_CR) begin
                end else if (b == hfve_pkg::CH_SP || b == hfve_pkg::CH_TAB)
                    hold_ws(1'b0);
                else if (b == hfve_pkg::CH_LF)
                    nl_held = 1'b1;
                else
                    flush_and_print(b);
            end
            default: ph = hfve_pkg::PH_DONE;
        endcase

        if (it.end_of_buffer) begin
            if (ph == hfve_pkg::PH_LEAD || ph == hfve_pkg::PH_VALUE)
                post(hfve_pkg::KIND_COMPLETE, 8'h00);
            else if (ph != hfve_pkg::PH_DONE)
                post(hfve_pkg::KIND_NO_MATCH, 8'h00);
            clear_parse();
        end

        if (step_n > 0) begin
            last_r          = value_q.pop_back();
            last_r.run_last = 1'b1;
            value_q.push_back(last_r);
        end
    endtask

    always @(posedge i_clk) begin
        hfve_pkg::t_out_item want;
        if (!i_rst_n) begin
            name_len_reg = 5'd1;
            name_lo_reg  = '0;
            name_hi_reg  = '0;
            clear_parse();
            value_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    hfve_pkg::CFG_NAME_LEN:  name_len_reg = i_cfg_data[4:0];
                    hfve_pkg::CFG_NAME_LOW:  name_lo_reg  = i_cfg_data;
                    hfve_pkg::CFG_NAME_HIGH: name_hi_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                predict_item(i_in);
            if (i_pop && !i_empty) begin
                if (value_q.size() == 0) begin
                    $error("unexpected result: kind %0d, out_byte %02h", i_out.kind,
                           i_out.out_byte);
                    fails++;
                end else begin
                    want = value_q.pop_front();
                    checked++;
                    if (want.pending_overflow) overflow_hits++;
                    if (i_out.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out.kind);
                        fails++;
                    end
                    if (i_out.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte,
                               i_out.out_byte);
                        fails++;
                    end
                    if (i_out.pending_overflow !== want.pending_overflow) begin
                        $error("pending_overflow: expected %0b, got %0b",
                               want.pending_overflow, i_out.pending_overflow);
                        fails++;
                    end
                    if (i_out.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last,
                               i_out.run_last);
                        fails++;
                    end
                end
            end
        end
        waiting = value_q.size();
    end

endmodule

// ===== tb/header_field_value_extract_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the header field value extractor: drives header buffers and name
// settings, pops results at random. Uses hfve_pkg, the block and its checker.
module header_field_value_extract_top_test;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [1:0]          i_cfg_index = hfve_pkg::CFG_NAME_LEN;
    logic [63:0]         i_cfg_data  = '0;
    logic                push        = 1'b0;
    logic                pop         = 1'b0;
    hfve_pkg::t_in_item  in_item     = '0;
    logic                o_cfg_ready;
    logic                full;
    logic                empty;
    hfve_pkg::t_out_item out_item;

    int fail_count;
    int results_waiting;
    int results_checked;
    int overflow_results;

    int send_idle_pct = 10;
    int recv_idle_pct = 65;
    int bytes_sent    = 0;
    int buffers_sent  = 0;

    logic [7:0]         name_chars [16];
    int                 name_len_set;
    hfve_pkg::t_in_item hdr_q [$];

    header_field_value_extract_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in        (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out       (out_item)
    );

    header_field_value_extract_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_in            (in_item),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out           (out_item),
        .o_fail_count    (fail_count),
        .o_waiting       (results_waiting),
        .o_checked       (results_checked),
        .o_overflow_hits (overflow_results)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [7:0] any_printable();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == hfve_pkg::CH_TAB || b == hfve_pkg::CH_LF || b == hfve_pkg::CH_CR
               || b == hfve_pkg::CH_SP);
        return b;
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return 8'h2D;
            2, 3:    return 8'($urandom_range(8'h41, 8'h5A));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic letter;
        letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        return (letter && $urandom_range(0, 1) == 1) ? c ^ 8'h20 : c;
    endfunction

    task automatic put(input logic [7:0] b, input logic eob);
        hfve_pkg::t_in_item t;
        t.in_byte       = b;
        t.end_of_buffer = eob;
        hdr_q.push_back(t);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i], 1'b0);
    endtask

    task automatic mark_end();
        hfve_pkg::t_in_item t;
        t               = hdr_q.pop_back();
        t.end_of_buffer = 1'b1;
        hdr_q.push_back(t);
    endtask

    task automatic send_item(input hfve_pkg::t_in_item it);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        if (it.end_of_buffer) buffers_sent++;
    endtask

    task automatic send_buffer();
        foreach (hdr_q[i])
            send_item(hdr_q[i]);
        hdr_q.delete();
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        wait (results_waiting == 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_name();
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = name_chars[i];
            hi[8*i +: 8] = name_chars[i+8];
        end
        drain();
        repeat (20) @(negedge i_clk);
        write_reg(hfve_pkg::CFG_NAME_LEN, 64'(name_len_set));
        write_reg(hfve_pkg::CFG_NAME_LOW, lo);
        write_reg(hfve_pkg::CFG_NAME_HIGH, hi);
    endtask

    task automatic put_lead();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
                0: put(hfve_pkg::CH_SP, 1'b0);
                1: put(hfve_pkg::CH_TAB, 1'b0);
                2: put(hfve_pkg::CH_CR, 1'b0);
                3: begin
                    put(hfve_pkg::CH_LF, 1'b0);
                    case ($urandom_range(0, 3))
                        0: put(hfve_pkg::CH_SP, 1'b0);
                        1: put(hfve_pkg::CH_TAB, 1'b0);
                        2: put(hfve_pkg::CH_CR, 1'b0);
                        default: put(hfve_pkg::CH_LF, 1'b0);
                    endcase
                end
                default: put(hfve_pkg::CH_LF, 1'b0);
            endcase
        end
    endtask

    task automatic put_value();
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 19))
                8, 9, 10: put(hfve_pkg::CH_SP, 1'b0);
                11, 12:   put(hfve_pkg::CH_TAB, 1'b0);
                13:       put(hfve_pkg::CH_CR, 1'b0);
                14, 15: begin
                    put(hfve_pkg::CH_LF, 1'b0);
                    put($urandom_range(0, 1) ? hfve_pkg::CH_SP : hfve_pkg::CH_TAB, 1'b0);
                end
                16: begin
                    // long whitespace run of 28 to 40 bytes, which can spill the 32-entry trailing-space store
                    repeat ($urandom_range(28, 40))
                        put($urandom_range(0, 3) == 0 ? hfve_pkg::CH_TAB : hfve_pkg::CH_SP,
                            1'b0);
                    if ($urandom_range(0, 1)) put(any_printable(), 1'b0);
                end
                default: put(any_printable(), 1'b0);
            endcase
        end
    endtask

    task automatic put_line();
        int eff;
        int cut;
        int k;
        eff = (name_len_set > 16) ? 16 : name_len_set;
        k   = $urandom_range(0, 9);
        if (k < 5) begin
            for (int i = 0; i < eff; i++) put(flip_case(name_chars[i]), 1'b0);
            put(hfve_pkg::CH_COLON, 1'b0);
            put_lead();
            put_value();
        end else if (k < 7) begin
            repeat ($urandom_range(1, 6)) put(pick_name_char(), 1'b0);
            put(hfve_pkg::CH_COLON, 1'b0);
            put(hfve_pkg::CH_SP, 1'b0);
            put_value();
        end else if (k < 8) begin
            put(hfve_pkg::CH_TAB, 1'b0);
            for (int i = 0; i < eff; i++) put(name_chars[i], 1'b0);
            put(hfve_pkg::CH_COLON, 1'b0);
            put_value();
        end else begin
            cut = $urandom_range(0, eff);
            for (int i = 0; i < cut; i++) put(name_chars[i], 1'b0);
            put(any_printable(), 1'b0);
            put_value();
        end
        if ($urandom_range(0, 3) == 0) put(hfve_pkg::CH_CR, 1'b0);
        put(hfve_pkg::CH_LF, 1'b0);
    endtask

    task automatic build_buffer();
        int cut;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 3)) put_line();
        end
        case ($urandom_range(0, 3))
            0: put(hfve_pkg::CH_NUL, 1'b1);
            1: begin
                put(hfve_pkg::CH_NUL, 1'b0);
                repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
                mark_end();
            end
            2: mark_end();
            default: begin
                cut = $urandom_range(1, hdr_q.size());
                while (hdr_q.size() > cut) void'(hdr_q.pop_back());
                mark_end();
            end
        endcase
    endtask

    task automatic setup_phase(input int p);
        for (int i = 0; i < 16; i++) name_chars[i] = pick_name_char();
        case (p)
            0: begin
                name_len_set = 0;
                for (int i = 0; i < 16; i++) name_chars[i] = 8'h00;
            end
            1: name_len_set = 16;
            2: name_len_set = 31;
            3: begin
                name_len_set = 1;
                for (int i = 0; i < 16; i++) name_chars[i] = 8'hFF;
            end
            4: begin
                name_len_set = $urandom_range(3, 12);
                name_chars[$urandom_range(0, name_len_set - 1)] = hfve_pkg::CH_LF;
            end
            default: begin
                name_len_set = $urandom_range(1, 8);
                for (int i = 8; i < 16; i++) name_chars[i] = 8'h00;
            end
        endcase
        program_name();
    endtask

    initial begin
        int phase_start;
        int nbuf;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field name "Ab"
        name_len_set = 2;
        for (int i = 0; i < 16; i++) name_chars[i] = 8'h00;
        name_chars[0] = 8'h41;
        name_chars[1] = 8'h62;
        program_name();
        put_str("ab:\n");
        put(hfve_pkg::CH_NUL, 1'b1);
        put_str("\tab:x\nAb: \ty  z");
        put(8'hFF, 1'b1);
        put(8'h61, 1'b1);
        put(hfve_pkg::CH_NUL, 1'b0);
        put(8'hFF, 1'b1);
        send_buffer();

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 10;
                recv_idle_pct = 65;
            end else if (p < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setup_phase(p);
            phase_start = bytes_sent;
            nbuf        = 0;
            while (bytes_sent - phase_start < 58) begin
                build_buffer();
                if (nbuf % 12 == 5) drain();
                send_buffer();
                nbuf++;
            end
        end

        drain();
        repeat (30) @(posedge i_clk);

        $display("Sent %0d header bytes in %0d buffers under 7 name settings;", bytes_sent,
                 buffers_sent);
        $display("checked %0d results, %0d of them flagged for dropped whitespace.",
                 results_checked, overflow_results);
        if (fail_count == 0 && results_waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
